@@ sv/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  // Result status codes.
  localparam logic [1:0] ST_UNIT = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Lead bytes that narrow the range of the second byte.
  localparam logic [7:0] LEAD_MIN2  = 8'hC2;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] SEC_E0_MIN = 8'hA0;
  localparam logic [7:0] SEC_ED_MAX = 8'h9F;
  localparam logic [7:0] SEC_F0_MIN = 8'h90;
  localparam logic [7:0] SEC_F4_MAX = 8'h8F;

  // Surrogate construction.
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] PLANE1     = 21'h10000;

  // Output queue depth; the input side needs room for two results.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result beat.
  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        last_of_string;
  } result_t;

endpackage

@@ sv/u8u16_if.sv @@
// Channel interfaces for the byte input and the code unit output.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last_of_string;
  modport source (output valid, output code_unit, output status, output last_of_string,
                  input ready);
  modport sink (input valid, input code_unit, input status, input last_of_string,
                output ready);
endinterface

@@ sv/utf8_to_utf16_validating_decoder_core.sv @@
// Top level of the UTF-8 to UTF-16 validating decoder.
//
// byte_in carries one UTF-8 byte per beat; unit_out carries one result per
// beat: a UTF-16 code unit, an end-of-string mark, or an error. A code point
// above 0xFFFF gives two beats (high then low surrogate). A zero byte at a
// character boundary ends the string. After an error, bytes are dropped up
// to and including the next zero byte.
// Each accepted byte is decoded in the cycle it is taken, and its results are
// written to a four-entry output queue; from an empty queue the first result
// is visible on unit_out in the next cycle. One byte can be taken every
// cycle; the queue must hold two free entries for a byte to be taken.
// A four-byte character takes four bytes and gives two beats, so a receiver
// that takes a beat every cycle never holds up the input.
// When the receiver stalls the queue fills and byte_in.ready drops.
// cfg_wr_en writes the unit capacity max_units (reset 65535); write it only
// while the block is idle. Synchronous reset empties the queue and clears the
// decoding state.
module utf8_to_utf16_validating_decoder_core
  import u8u16_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  u8u16_byte_if.sink    byte_in,
  u8u16_unit_if.source  unit_out
);

  logic [15:0] max_units;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic [7:0]  lead_value, lead_value_next;
  logic [20:0] point_accumulator, point_accumulator_next;
  logic [15:0] units_written, units_written_next;
  logic        discarding, discarding_next;

  result_t     queue [QDEPTH];
  logic [QAW-1:0] rd_ptr, wr_ptr;
  logic [QAW:0]   count;

  logic        accept, pop;
  logic [1:0]  n_res;
  result_t     res0, res1;

  logic [7:0]  b;
  logic        close_en;
  logic [1:0]  close_st;
  logic        ok, second;
  logic [20:0] acc_shift;
  logic [19:0] pair_v;
  logic [1:0]  rem_dec;

  assign b      = byte_in.data_byte;
  assign accept = byte_in.valid && byte_in.ready;
  assign pop    = unit_out.valid && unit_out.ready;

  // Room for two results keeps a surrogate pair in one write.
  assign byte_in.ready = (count <= (QAW + 1)'(QDEPTH - 2));

  assign unit_out.valid          = (count != '0);
  assign unit_out.code_unit      = queue[rd_ptr].code_unit;
  assign unit_out.status         = queue[rd_ptr].status;
  assign unit_out.last_of_string = queue[rd_ptr].last_of_string;

  // Continuation byte checks, including the narrowed second byte ranges.
  always_comb begin
    second = ((lead_value >= LEAD_E0) && (lead_value < LEAD_F0) && (bytes_remaining == 2'd2))
          || ((lead_value >= LEAD_F0) && (bytes_remaining == 2'd3));
    ok = (b[7:6] == 2'b10);
    if (second) begin
      if ((lead_value == LEAD_E0) && (b < SEC_E0_MIN)) ok = 1'b0;
      if ((lead_value == LEAD_ED) && (b > SEC_ED_MAX)) ok = 1'b0;
      if ((lead_value == LEAD_F0) && (b < SEC_F0_MIN)) ok = 1'b0;
      if ((lead_value == LEAD_F4) && (b > SEC_F4_MAX)) ok = 1'b0;
    end
    acc_shift = {point_accumulator[14:0], b[5:0]};
    pair_v    = 20'(acc_shift - PLANE1);
    rem_dec   = bytes_remaining - 2'd1;
  end

  // Decode one byte against the running state.
  always_comb begin
    bytes_remaining_next   = bytes_remaining;
    lead_value_next        = lead_value;
    point_accumulator_next = point_accumulator;
    units_written_next     = units_written;
    discarding_next        = discarding;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;
    close_en = 1'b0;
    close_st = ST_END;

    if (discarding) begin
      if (b == 8'd0) begin
        discarding_next    = 1'b0;
        units_written_next = '0;
      end
    end else if (bytes_remaining == 2'd0) begin
      if (b == 8'd0) begin
        close_en = 1'b1;
        close_st = ST_END;
      end else if (units_written >= max_units) begin
        close_en = 1'b1;
        close_st = ST_OVF;
      end else if (b[7] == 1'b0) begin
        n_res = 2'd1;
        res0  = '{code_unit: {8'd0, b}, status: ST_UNIT, last_of_string: 1'b0};
        units_written_next = units_written + 16'd1;
      end else if ((b[7:5] == 3'b110) && (b >= LEAD_MIN2)) begin
        point_accumulator_next = {16'd0, b[4:0]};
        lead_value_next        = b;
        bytes_remaining_next   = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        point_accumulator_next = {17'd0, b[3:0]};
        lead_value_next        = b;
        bytes_remaining_next   = 2'd2;
      end else if ((b[7:3] == 5'b11110) && (b <= LEAD_F4)) begin
        point_accumulator_next = {18'd0, b[2:0]};
        lead_value_next        = b;
        bytes_remaining_next   = 2'd3;
      end else begin
        close_en = 1'b1;
        close_st = ST_BAD;
      end
    end else if (!ok) begin
      close_en = 1'b1;
      close_st = ST_BAD;
    end else begin
      bytes_remaining_next = rem_dec;
      if (rem_dec != 2'd0) begin
        point_accumulator_next = acc_shift;
      end else begin
        lead_value_next        = '0;
        point_accumulator_next = '0;
        if (lead_value >= LEAD_F0) begin
          if (({1'b0, units_written} + 17'd2) > {1'b0, max_units}) begin
            close_en = 1'b1;
            close_st = ST_OVF;
          end else begin
            n_res = 2'd2;
            res0  = '{code_unit: HI_SURR | {6'd0, pair_v[19:10]}, status: ST_UNIT,
                      last_of_string: 1'b0};
            res1  = '{code_unit: LO_SURR | {6'd0, pair_v[9:0]}, status: ST_UNIT,
                      last_of_string: 1'b0};
            units_written_next = units_written + 16'd2;
          end
        end else begin
          n_res = 2'd1;
          res0  = '{code_unit: acc_shift[15:0], status: ST_UNIT, last_of_string: 1'b0};
          units_written_next = units_written + 16'd1;
        end
      end
    end

    // End and error results close the string and clear the character state.
    if (close_en) begin
      n_res = 2'd1;
      res0  = '{code_unit: 16'd0, status: close_st, last_of_string: 1'b1};
      bytes_remaining_next   = '0;
      lead_value_next        = '0;
      point_accumulator_next = '0;
      units_written_next     = '0;
      discarding_next        = (close_st == ST_BAD || close_st == ST_OVF) && (b != 8'd0);
    end
  end

  // Configuration register and decoding state.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units         <= 16'hFFFF;
      bytes_remaining   <= '0;
      lead_value        <= '0;
      point_accumulator <= '0;
      units_written     <= '0;
      discarding        <= 1'b0;
    end else begin
      if (cfg_wr_en) max_units <= cfg_wr_data;
      if (accept) begin
        bytes_remaining   <= bytes_remaining_next;
        lead_value        <= lead_value_next;
        point_accumulator <= point_accumulator_next;
        units_written     <= units_written_next;
        discarding        <= discarding_next;
      end
    end
  end

  // Output queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      if (accept) wr_ptr <= wr_ptr + QAW'(n_res);
      count <= count + (accept ? (QAW + 1)'(n_res) : '0) - (QAW + 1)'(pop);
    end
  end

  // Output queue storage: up to two result beats written per byte.
  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) queue[wr_ptr] <= res0;
    if (accept && (n_res == 2'd2)) queue[wr_ptr + QAW'(1)] <= res1;
  end

endmodule

@@ sv/u8u16_checker.sv @@
// Port checker for the UTF-8 to UTF-16 decoder, bound to the top level.
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic [1:0]  status,
  input logic        last_of_string
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(status)
      && $stable(last_of_string))
    else $error("result beat changed while stalled");

  // End and error beats carry a zero code unit.
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_UNIT) |-> code_unit == 16'd0)
    else $error("nonzero code unit on an end or error beat");

  // Exactly the end and error beats close a string.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_of_string == (status != ST_UNIT))
    else $error("last_of_string does not match status");

  // A high surrogate is always followed by a low surrogate.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (status == ST_UNIT) && (code_unit[15:10] == 6'b110110)
    |=> out_valid && (status == ST_UNIT) && (code_unit[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

  // Reset empties the output queue, so the input side is open right after.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("queue not empty right after reset");

endmodule

bind utf8_to_utf16_validating_decoder_core u8u16_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (byte_in.ready),
  .out_valid      (unit_out.valid),
  .out_ready      (unit_out.ready),
  .code_unit      (unit_out.code_unit),
  .status         (unit_out.status),
  .last_of_string (unit_out.last_of_string)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 validating decoder core.
module tb_top
  import u8u16_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  // Transcoder predictor: tracks decode state and holds the results still owed.
  class utf16_scoreboard;
    logic [15:0] max_units;
    logic [1:0]  bytes_left;
    logic [7:0]  lead;
    logic [20:0] point;
    logic [15:0] units;
    bit          skipping;
    result_t     owed_q[$];
    int          errors;
    int          n_status[4];

    function new();
      max_units  = 16'hFFFF;
      bytes_left = '0;
      lead       = '0;
      point      = '0;
      units      = '0;
      skipping   = 1'b0;
      errors     = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [15:0] u, logic [1:0] st, logic fin);
      result_t r;
      r.code_unit      = u;
      r.status         = st;
      r.last_of_string = fin;
      owed_q.push_back(r);
    endfunction

    // An end or error result closes the string and clears the character state.
    function void close_string(logic [1:0] st, logic [7:0] b);
      owe(16'h0000, st, 1'b1);
      bytes_left = '0;
      lead       = '0;
      point      = '0;
      units      = '0;
      skipping   = (st == ST_BAD || st == ST_OVF) && (b != 8'h00);
    endfunction

    // Work out the results caused by one accepted input beat.
    function void note_byte(logic [7:0] b);
      logic        ok;
      logic        second;
      logic [20:0] offs;
      if (skipping) begin
        if (b == 8'h00) begin
          skipping = 1'b0;
          units    = '0;
        end
        return;
      end
      // Character boundary: end, capacity check, then judge the lead byte.
      if (bytes_left == 2'd0) begin
        if (b == 8'h00) begin
          close_string(ST_END, b);
        end else if (units >= max_units) begin
          close_string(ST_OVF, b);
        end else if (b < 8'h80) begin
          owe({8'h00, b}, ST_UNIT, 1'b0);
          units++;
        end else if (b[7:5] == 3'b110 && b >= LEAD_MIN2) begin
          point      = {16'h0, b[4:0]};
          lead       = b;
          bytes_left = 2'd1;
        end else if (b[7:4] == 4'hE) begin
          point      = {17'h0, b[3:0]};
          lead       = b;
          bytes_left = 2'd2;
        end else if (b[7:3] == 5'b11110 && b <= LEAD_F4) begin
          point      = {18'h0, b[2:0]};
          lead       = b;
          bytes_left = 2'd3;
        end else begin
          close_string(ST_BAD, b);
        end
        return;
      end
      // Continuation byte, with narrowed ranges right after some leads.
      ok     = (b[7:6] == 2'b10);
      second = (lead[7:4] == 4'hE && bytes_left == 2'd2) ||
               (lead >= LEAD_F0 && bytes_left == 2'd3);
      if (second) begin
        if (lead == LEAD_E0 && b < SEC_E0_MIN) ok = 1'b0;
        if (lead == LEAD_ED && b > SEC_ED_MAX) ok = 1'b0;
        if (lead == LEAD_F0 && b < SEC_F0_MIN) ok = 1'b0;
        if (lead == LEAD_F4 && b > SEC_F4_MAX) ok = 1'b0;
      end
      if (!ok) begin
        close_string(ST_BAD, b);
        return;
      end
      point = {point[14:0], b[5:0]};
      bytes_left--;
      if (bytes_left != 2'd0) return;
      // Character complete: one unit, or a surrogate pair if it fits.
      if (lead >= LEAD_F0) begin
        if ({1'b0, units} + 17'd2 > {1'b0, max_units}) begin
          close_string(ST_OVF, b);
        end else begin
          offs = point - PLANE1;
          owe(HI_SURR | {6'h0, offs[19:10]}, ST_UNIT, 1'b0);
          owe(LO_SURR | {6'h0, offs[9:0]}, ST_UNIT, 1'b0);
          units += 16'd2;
        end
      end else begin
        owe(point[15:0], ST_UNIT, 1'b0);
        units++;
      end
      lead  = '0;
      point = '0;
    endfunction

    // Compare one output beat with the oldest owed result.
    function void check_unit(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: code_unit %h status %0d last_of_string %0b",
               got.code_unit, got.status, got.last_of_string);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      n_status[want.status]++;
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last_of_string !== want.last_of_string) begin
        $error("last_of_string: expected %0b, got %0b",
               want.last_of_string, got.last_of_string);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          n_settings = 0;
  bit          idle_on = 1'b1;
  logic [7:0]  seq_q[$];

  utf16_scoreboard sb = new();

  u8u16_byte_if in_ch ();
  u8u16_unit_if out_ch ();

  utf8_to_utf16_validating_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_in     (in_ch),
    .unit_out    (out_ch)
  );

  always #1 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side: check the beat taken at this edge, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_unit(result_t'{out_ch.code_unit, out_ch.status, out_ch.last_of_string});
    end
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 32) : 1'b1;
  end

  // Send one byte, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_seq();
    while (seq_q.size() != 0) send_byte(seq_q.pop_front());
  endtask

  // Drain all results, let the core settle, then write the capacity.
  task automatic write_capacity(input logic [15:0] cap);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.max_units = cap;
    n_settings++;
  endtask

  function automatic logic [7:0] pick(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Append one well-formed character of 1 to 4 bytes.
  function automatic void add_char(int len);
    logic [7:0] ld;
    case (len)
      1: seq_q.push_back(pick(8'h01, 8'h7F));
      2: begin
        seq_q.push_back(pick(LEAD_MIN2, 8'hDF));
        seq_q.push_back(pick(8'h80, 8'hBF));
      end
      3: begin
        ld = pick(LEAD_E0, 8'hEF);
        seq_q.push_back(ld);
        if (ld == LEAD_E0) seq_q.push_back(pick(SEC_E0_MIN, 8'hBF));
        else if (ld == LEAD_ED) seq_q.push_back(pick(8'h80, SEC_ED_MAX));
        else seq_q.push_back(pick(8'h80, 8'hBF));
        seq_q.push_back(pick(8'h80, 8'hBF));
      end
      default: begin
        ld = pick(LEAD_F0, LEAD_F4);
        seq_q.push_back(ld);
        if (ld == LEAD_F0) seq_q.push_back(pick(SEC_F0_MIN, 8'hBF));
        else if (ld == LEAD_F4) seq_q.push_back(pick(8'h80, SEC_F4_MAX));
        else seq_q.push_back(pick(8'h80, 8'hBF));
        seq_q.push_back(pick(8'h80, 8'hBF));
        seq_q.push_back(pick(8'h80, 8'hBF));
      end
    endcase
  endfunction

  // Append one malformed fragment.
  function automatic void add_fault();
    case ($urandom_range(5))
      0: seq_q.push_back($urandom_range(1) ? pick(8'h80, 8'hC1) : pick(8'hF5, 8'hFF));
      1: begin
        // Lead byte and at most one continuation byte, which leaves longer characters truncated.
        seq_q.push_back(pick(8'hC2, 8'hF4));
        if ($urandom_range(1)) seq_q.push_back(pick(8'h80, 8'hBF));
      end
      2: begin
        case ($urandom_range(3))
          0: begin seq_q.push_back(LEAD_E0); seq_q.push_back(pick(8'h80, 8'h9F)); end
          1: begin seq_q.push_back(LEAD_ED); seq_q.push_back(pick(8'hA0, 8'hBF)); end
          2: begin seq_q.push_back(LEAD_F0); seq_q.push_back(pick(8'h80, 8'h8F)); end
          default: begin seq_q.push_back(LEAD_F4); seq_q.push_back(pick(8'h90, 8'hBF)); end
        endcase
      end
      3: begin
        seq_q.push_back(pick(LEAD_MIN2, LEAD_F4));
        seq_q.push_back($urandom_range(1) ? pick(8'h01, 8'h7F) : pick(8'hC0, 8'hFF));
      end
      4: seq_q.push_back(pick(8'h00, 8'hFF));
      default: begin
        // Zero byte in the middle of a character.
        seq_q.push_back(pick(8'hC2, 8'hF4));
        seq_q.push_back(8'h00);
      end
    endcase
  endfunction

  // Random strings: mostly well formed, some broken, some pure noise.
  task automatic run_strings(input int target);
    int start_cnt;
    int r;
    int n;
    int cut;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < target) begin
      r = $urandom_range(99);
      n = $urandom_range(6);
      if (r < 95) begin
        cut = (r >= 75) ? $urandom_range(n) : -1;
        for (int i = 0; i <= n; i++) begin
          if (i == cut) add_fault();
          if (i < n) add_char($urandom_range(4, 1));
        end
      end else begin
        for (int i = 0; i <= n; i++) seq_q.push_back(pick(8'h00, 8'hFF));
      end
      if ($urandom_range(19) != 0) seq_q.push_back(8'h00);
      flush_seq();
    end
  endtask

  initial begin
    logic [15:0] caps[8];
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: range extremes, surrogate pair limits, second byte ranges.
    seq_q = '{8'h41, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
              8'hE0, 8'h9F, 8'h00, 8'hED, 8'hA0, 8'h00,
              8'hF0, 8'h8F, 8'h00, 8'hF4, 8'h90, 8'h00,
              8'hE1, 8'h00, 8'h00};
    flush_seq();
    // Capacity one: a pair that does not fit, then overflow at a lead byte.
    write_capacity(16'd1);
    seq_q = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'h00, 8'h41, 8'h42, 8'h00};
    flush_seq();

    // Random phases over several capacities; one phase runs without idling.
    caps = '{16'd0, 16'd2, 16'd3, 16'd5, 16'($urandom_range(8)), 16'hFFFF,
             16'($urandom_range(16'hFFFF)), 16'd1};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      idle_on = (i != 5);
      run_strings(100);
    end
    idle_on = 1'b1;

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes under %0d capacity writes.", bytes_sent, n_settings);
    $display("Checked %0d code units, %0d string ends, %0d invalid, %0d overflows.",
             sb.n_status[ST_UNIT], sb.n_status[ST_END], sb.n_status[ST_BAD],
             sb.n_status[ST_OVF]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
